// File: rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Holds screen geometry, field widths, opcodes and the controller/datapath
// command and status structures. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int ADDR_W         = $clog2(CELL_COUNT);

    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CELL_W = CHAR_W + ATTR_W;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_TEXT_ATTRIBUTE = 1'b0;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE    = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE      = 8'h20;
    localparam logic [ATTR_W-1:0] CLEAR_ATTRIBUTE = 8'h07;
    localparam logic [ATTR_W-1:0] ATTRIBUTE_RESET = 8'h07;

    typedef enum logic [OP_W-1:0] {
        OP_PUT_CHAR = 2'd0,
        OP_PUT_AT   = 2'd1,
        OP_READ     = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        WA_CURSOR,
        WA_POS,
        WA_PTR_PREV,
        WA_PTR
    } wa_sel_t;

    typedef enum logic [2:0] {
        WD_PUT_CHAR,
        WD_PUT_AT,
        WD_COPY,
        WD_ZERO,
        WD_SPACE
    } wd_sel_t;

    typedef enum logic {
        RA_POS,
        RA_PTR_BELOW
    } ra_sel_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_ADVANCE,
        CUR_NEWLINE,
        CUR_COL_HOME,
        CUR_HOME
    } cur_op_t;

    typedef struct packed {
        logic    load_item;
        logic    wr_en;
        wa_sel_t wa_sel;
        wd_sel_t wd_sel;
        logic    rd_en;
        ra_sel_t ra_sel;
        logic    ptr_clear;
        logic    ptr_inc;
        cur_op_t cur_op;
        logic    value_clear;
        logic    value_capture;
        logic    set_scroll;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic is_newline;
        logic row_last;
        logic pos_ok;
        logic ptr_zero;
        logic ptr_fill_start;
        logic ptr_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/tcw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the screen cell store. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/tcw_datapath.sv
// Datapath of the text console writer: item capture, cursor, attribute
// register, sweep pointer, screen RAM and the output register.
// Depends on tcw_pkg and tcw_ram.
`timescale 1ns / 1ps
`default_nettype none

module tcw_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire tcw_pkg::dp_cmd_t             cmd,
    output tcw_pkg::dp_status_t               status,
    input  wire logic                         attr_we,
    input  wire logic [tcw_pkg::ATTR_W-1:0]   attr_wdata,
    output logic      [tcw_pkg::ATTR_W-1:0]   text_attribute,
    input  wire logic [tcw_pkg::OP_W-1:0]     op,
    input  wire logic [tcw_pkg::CHAR_W-1:0]   char_code,
    input  wire logic [tcw_pkg::COL_W-1:0]    pos_column,
    input  wire logic [tcw_pkg::ROW_W-1:0]    pos_row,
    input  wire logic [tcw_pkg::ATTR_W-1:0]   cell_attribute,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [tcw_pkg::CELL_W-1:0]   cell_value,
    output logic      [tcw_pkg::COL_W-1:0]    cursor_column,
    output logic      [tcw_pkg::ROW_W-1:0]    cursor_row,
    output logic                              did_scroll
);

    import tcw_pkg::*;

    op_t               item_op_reg;
    logic [CHAR_W-1:0] item_char_reg;
    logic [COL_W-1:0]  item_col_reg;
    logic [ROW_W-1:0]  item_row_reg;
    logic [ATTR_W-1:0] item_attr_reg;

    logic [ATTR_W-1:0] attr_reg;
    logic [COL_W-1:0]  cursor_col_reg, cursor_col_next;
    logic [ROW_W-1:0]  cursor_row_reg, cursor_row_next;
    logic [ADDR_W-1:0] ptr_reg;
    logic [CELL_W-1:0] value_reg;
    logic              scroll_reg;

    logic              out_valid_reg;
    logic [CELL_W-1:0] out_value_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic              out_scroll_reg;

    logic [ADDR_W-1:0] cursor_addr;
    logic [ADDR_W-1:0] pos_addr;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [CELL_W-1:0] wdata;
    logic [CELL_W-1:0] rdata;
    logic              col_last;
    logic              row_last;

    assign cursor_addr = ADDR_W'(cursor_row_reg) * ADDR_W'(SCREEN_COLUMNS)
                       + ADDR_W'(cursor_col_reg);
    assign pos_addr    = ADDR_W'(item_row_reg) * ADDR_W'(SCREEN_COLUMNS)
                       + ADDR_W'(item_col_reg);

    assign col_last = (cursor_col_reg == COL_W'(SCREEN_COLUMNS - 1));
    assign row_last = (cursor_row_reg == ROW_W'(SCREEN_ROWS - 1));

    always_comb
    begin
        unique case (cmd.wa_sel)
            WA_CURSOR:   waddr = cursor_addr;
            WA_POS:      waddr = pos_addr;
            WA_PTR_PREV: waddr = ptr_reg - ADDR_W'(1);
            WA_PTR:      waddr = ptr_reg;
            default:     waddr = ptr_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.wd_sel)
            WD_PUT_CHAR: wdata = {attr_reg, item_char_reg};
            WD_PUT_AT:   wdata = {item_attr_reg, item_char_reg};
            WD_COPY:     wdata = rdata;
            WD_ZERO:     wdata = '0;
            WD_SPACE:    wdata = {CLEAR_ATTRIBUTE, SPACE_CODE};
            default:     wdata = '0;
        endcase
    end

    // The scroll copy reads one row below the pointer.
    assign raddr = (cmd.ra_sel == RA_PTR_BELOW) ? ptr_reg + ADDR_W'(SCREEN_COLUMNS)
                                                : pos_addr;

    tcw_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELL_COUNT)
    ) u_screen (
        .clk  (clk),
        .we   (cmd.wr_en),
        .waddr(waddr),
        .wdata(wdata),
        .re   (cmd.rd_en),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb
    begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        unique case (cmd.cur_op)
            CUR_HOLD:
            begin
            end
            CUR_ADVANCE:
            begin
                if (col_last)
                begin
                    cursor_col_next = '0;
                    cursor_row_next = row_last ? '0 : cursor_row_reg + ROW_W'(1);
                end
                else
                begin
                    cursor_col_next = cursor_col_reg + COL_W'(1);
                end
            end
            CUR_NEWLINE:
            begin
                cursor_col_next = '0;
                cursor_row_next = cursor_row_reg + ROW_W'(1);
            end
            CUR_COL_HOME:
            begin
                cursor_col_next = '0;
            end
            CUR_HOME:
            begin
                cursor_col_next = '0;
                cursor_row_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg       <= ATTRIBUTE_RESET;
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (attr_we)
            begin
                attr_reg <= attr_wdata;
            end
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_op_reg   <= op_t'(op);
            item_char_reg <= char_code;
            item_col_reg  <= pos_column;
            item_row_reg  <= pos_row;
            item_attr_reg <= cell_attribute;
        end
        if (cmd.ptr_clear)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_reg <= ptr_reg + ADDR_W'(1);
        end
        if (cmd.value_clear)
        begin
            value_reg  <= '0;
            scroll_reg <= 1'b0;
        end
        else
        begin
            if (cmd.value_capture)
            begin
                value_reg <= rdata;
            end
            if (cmd.set_scroll)
            begin
                scroll_reg <= 1'b1;
            end
        end
        if (cmd.load_out)
        begin
            out_value_reg  <= value_reg;
            out_col_reg    <= cursor_col_reg;
            out_row_reg    <= cursor_row_reg;
            out_scroll_reg <= scroll_reg;
        end
    end

    assign status.op             = item_op_reg;
    assign status.is_newline     = (item_char_reg == NEWLINE_CODE);
    assign status.row_last       = row_last;
    assign status.pos_ok         = (int'(item_col_reg) < SCREEN_COLUMNS)
                                && (int'(item_row_reg) < SCREEN_ROWS);
    assign status.ptr_zero       = (ptr_reg == '0);
    assign status.ptr_fill_start = (ptr_reg == ADDR_W'(CELL_COUNT - SCREEN_COLUMNS));
    assign status.ptr_last       = (ptr_reg == ADDR_W'(CELL_COUNT - 1));
    assign status.out_free       = !out_valid_reg || out_ready;

    assign text_attribute = attr_reg;
    assign out_valid      = out_valid_reg;
    assign cell_value     = out_value_reg;
    assign cursor_column  = out_col_reg;
    assign cursor_row     = out_row_reg;
    assign did_scroll     = out_scroll_reg;

endmodule

`default_nettype wire

// File: rtl/tcw_controller.sv
// Controller state machine of the text console writer.
// Sequences each transaction and the scroll and clear sweeps over the datapath.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_controller (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire tcw_pkg::dp_status_t  status,
    output tcw_pkg::dp_cmd_t          cmd
);

    import tcw_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCROLL_COPY,
        ST_SCROLL_FILL,
        ST_FILL_SPACE,
        ST_READ_WAIT,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next        = state_reg;
        cmd               = '0;
        cmd.wa_sel        = WA_PTR;
        cmd.wd_sel        = WD_ZERO;
        cmd.ra_sel        = RA_POS;
        cmd.cur_op        = CUR_HOLD;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.value_clear = 1'b1;
                unique case (status.op)
                    OP_PUT_CHAR:
                    begin
                        if (status.is_newline)
                        begin
                            if (status.row_last)
                            begin
                                cmd.ptr_clear = 1'b1;
                                state_next    = ST_SCROLL_COPY;
                            end
                            else
                            begin
                                cmd.cur_op = CUR_NEWLINE;
                                state_next = ST_DONE;
                            end
                        end
                        else
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wa_sel = WA_CURSOR;
                            cmd.wd_sel = WD_PUT_CHAR;
                            cmd.cur_op = CUR_ADVANCE;
                            state_next = ST_DONE;
                        end
                    end
                    OP_PUT_AT:
                    begin
                        cmd.wr_en  = status.pos_ok;
                        cmd.wa_sel = WA_POS;
                        cmd.wd_sel = WD_PUT_AT;
                        state_next = ST_DONE;
                    end
                    OP_READ:
                    begin
                        if (status.pos_ok)
                        begin
                            cmd.rd_en  = 1'b1;
                            state_next = ST_READ_WAIT;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.ptr_clear = 1'b1;
                        state_next    = ST_FILL_SPACE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SCROLL_COPY:
            begin
                // Read one row below the pointer and write the cell read in the
                // previous cycle one slot behind it.
                cmd.rd_en  = !status.ptr_fill_start;
                cmd.ra_sel = RA_PTR_BELOW;
                cmd.wr_en  = !status.ptr_zero;
                cmd.wa_sel = WA_PTR_PREV;
                cmd.wd_sel = WD_COPY;
                if (status.ptr_fill_start)
                begin
                    state_next = ST_SCROLL_FILL;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            ST_SCROLL_FILL:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_PTR;
                cmd.wd_sel = WD_ZERO;
                if (status.ptr_last)
                begin
                    cmd.cur_op     = CUR_COL_HOME;
                    cmd.set_scroll = 1'b1;
                    state_next     = ST_DONE;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            ST_FILL_SPACE:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_PTR;
                cmd.wd_sel = WD_SPACE;
                if (status.ptr_last)
                begin
                    cmd.cur_op = CUR_HOME;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            ST_READ_WAIT:
            begin
                cmd.value_capture = 1'b1;
                state_next        = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

// File: rtl/text_console_writer.sv
// Top level of the text console writer: APB register port, controller and
// datapath. Depends on tcw_pkg, tcw_controller, tcw_datapath and tcw_ram.
//
// Channel   Direction  Handshake               Payload
// config    in         psel/penable/pready     paddr, pwdata, prdata
// input     in         in_valid/in_ready       op, char_code, pos_column, pos_row,
//                                              cell_attribute
// result    out        out_valid/out_ready     cell_value, cursor_column, cursor_row,
//                                              did_scroll
//
// Put char, newline without scroll and put at pass through accept, decode and
// result load; a read adds a wait state for the registered RAM read.
// A newline on the last row runs a copy sweep that moves every row up by one,
// then a zero fill of the last row. A clear writes a space to every cell, one
// RAM write per cell.
// After reset the block is ready at once; the screen is not cleared by reset.
// A result waits in the output register; the next transaction is taken
// meanwhile and stalls only at its end until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tcw_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [tcw_pkg::PDATA_W-1:0]   pwdata,
    output logic      [tcw_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [tcw_pkg::OP_W-1:0]      op,
    input  wire logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  wire logic [tcw_pkg::COL_W-1:0]     pos_column,
    input  wire logic [tcw_pkg::ROW_W-1:0]     pos_row,
    input  wire logic [tcw_pkg::ATTR_W-1:0]    cell_attribute,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [tcw_pkg::CELL_W-1:0]    cell_value,
    output logic      [tcw_pkg::COL_W-1:0]     cursor_column,
    output logic      [tcw_pkg::ROW_W-1:0]     cursor_row,
    output logic                               did_scroll
);

    import tcw_pkg::*;

    dp_cmd_t           cmd;
    dp_status_t        status;
    logic              attr_sel;
    logic              attr_we;
    logic [ATTR_W-1:0] text_attribute;

    assign pready   = 1'b1;
    assign attr_sel = (paddr[PADDR_W-1:2] == REG_TEXT_ATTRIBUTE);
    assign attr_we  = psel && penable && pwrite && pready && attr_sel;
    assign prdata   = attr_sel ? PDATA_W'(text_attribute) : '0;

    tcw_controller u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tcw_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .attr_we       (attr_we),
        .attr_wdata    (pwdata[ATTR_W-1:0]),
        .text_attribute(text_attribute),
        .op            (op),
        .char_code     (char_code),
        .pos_column    (pos_column),
        .pos_row       (pos_row),
        .cell_attribute(cell_attribute),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cell_value    (cell_value),
        .cursor_column (cursor_column),
        .cursor_row    (cursor_row),
        .did_scroll    (did_scroll)
    );

    // Accepting an input always drops in_ready.
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on two consecutive cycles");

    // A scroll leaves the cursor at the start of the last row.
    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && did_scroll |->
            (cursor_row == ROW_W'(SCREEN_ROWS - 1)) && (cursor_column == '0))
        else $error("scroll result with cursor off the last row start");

    // The reported cursor always lies on the screen.
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (int'(cursor_column) < SCREEN_COLUMNS) && (int'(cursor_row) < SCREEN_ROWS))
        else $error("cursor reported off the screen");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for text_console_writer: directed and random console
// commands, checked against a screen and cursor model kept in the bench.
// Depends on tcw_pkg and the text_console_writer RTL.

module tb_top;
    import tcw_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 11;
    localparam int IDLE_PERCENT = 9;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 12000;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = CELL_COUNT + 16;
    localparam int PHASE_ITEMS  = 140;

    localparam logic [PADDR_W-1:0] ATTR_ADDR     = {REG_TEXT_ATTRIBUTE, 2'b00};
    localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = ATTR_ADDR + PADDR_W'(4);

    typedef struct packed {
        logic [CELL_W-1:0] cell_data;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic              scrolled;
    } console_output_t;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [PADDR_W-1:0] paddr          = '0;
    logic [PDATA_W-1:0] pwdata         = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid       = 1'b0;
    logic               in_ready;
    logic [OP_W-1:0]    op             = '0;
    logic [CHAR_W-1:0]  char_code      = '0;
    logic [COL_W-1:0]   pos_column     = '0;
    logic [ROW_W-1:0]   pos_row        = '0;
    logic [ATTR_W-1:0]  cell_attribute = '0;
    logic               out_valid;
    logic               out_ready      = 1'b0;
    logic [CELL_W-1:0]  cell_value;
    logic [COL_W-1:0]   cursor_column;
    logic [ROW_W-1:0]   cursor_row;
    logic               did_scroll;

    // Bench copy of the console state.
    logic [CELL_W-1:0]  screen_image [CELL_COUNT];
    int                 model_row  = 0;
    int                 model_col  = 0;
    logic [ATTR_W-1:0]  model_attr = ATTRIBUTE_RESET;

    console_output_t    console_outputs_due [$];
    int                 error_count     = 0;
    bit                 steady          = 1'b0;
    int                 holds_requested = 0;
    int                 holds_served    = 0;
    int                 hold_left       = 0;
    int                 stall_cycles    = 0;

    text_console_writer uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .char_code      (char_code),
        .pos_column     (pos_column),
        .pos_row        (pos_row),
        .cell_attribute (cell_attribute),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cell_value     (cell_value),
        .cursor_column  (cursor_column),
        .cursor_row     (cursor_row),
        .did_scroll     (did_scroll)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic note_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    // Applies one command to the bench state and returns what the block reports.
    function automatic console_output_t apply_console_op(op_t cmd, logic [CHAR_W-1:0] ch,
        logic [COL_W-1:0] col, logic [ROW_W-1:0] row, logic [ATTR_W-1:0] attr);
        console_output_t res;
        bit              on_screen;
        int              i;
        res       = '0;
        on_screen = (col < SCREEN_COLUMNS) && (row < SCREEN_ROWS);
        case (cmd)
            OP_PUT_CHAR:
            begin
                if (ch == NEWLINE_CODE)
                begin
                    model_col = 0;
                    if (model_row == SCREEN_ROWS - 1)
                    begin
                        // Whole rows move up and the freed last row reads as zero.
                        for (i = 0; i < CELL_COUNT - SCREEN_COLUMNS; i++)
                        begin
                            screen_image[i] = screen_image[i + SCREEN_COLUMNS];
                        end
                        for (i = CELL_COUNT - SCREEN_COLUMNS; i < CELL_COUNT; i++)
                        begin
                            screen_image[i] = '0;
                        end
                        res.scrolled = 1'b1;
                    end
                    else
                    begin
                        model_row++;
                    end
                end
                else
                begin
                    screen_image[model_row * SCREEN_COLUMNS + model_col] = {model_attr, ch};
                    model_col++;
                    if (model_col == SCREEN_COLUMNS)
                    begin
                        model_col = 0;
                        model_row = (model_row == SCREEN_ROWS - 1) ? 0 : model_row + 1;
                    end
                end
            end
            OP_PUT_AT:
            begin
                if (on_screen)
                begin
                    screen_image[row * SCREEN_COLUMNS + col] = {attr, ch};
                end
            end
            OP_READ:
            begin
                if (on_screen)
                begin
                    res.cell_data = screen_image[row * SCREEN_COLUMNS + col];
                end
            end
            OP_CLEAR:
            begin
                for (i = 0; i < CELL_COUNT; i++)
                begin
                    screen_image[i] = {CLEAR_ATTRIBUTE, SPACE_CODE};
                end
                model_row = 0;
                model_col = 0;
            end
        endcase
        res.column = model_col[COL_W-1:0];
        res.row    = model_row[ROW_W-1:0];
        return res;
    endfunction

    task automatic send_item(op_t cmd, logic [CHAR_W-1:0] ch, logic [COL_W-1:0] col,
                             logic [ROW_W-1:0] row, logic [ATTR_W-1:0] attr);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        op             <= cmd;
        char_code      <= ch;
        pos_column     <= col;
        pos_row        <= row;
        cell_attribute <= attr;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        console_outputs_due.push_back(apply_console_op(cmd, ch, col, row, attr));
    endtask

    function automatic logic [CHAR_W-1:0] text_byte();
        logic [CHAR_W-1:0] b;
        do
        begin
            b = CHAR_W'($urandom);
        end
        while (b == NEWLINE_CODE);
        return b;
    endfunction

    task automatic type_chars(int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            send_item(OP_PUT_CHAR, text_byte(), COL_W'($urandom), ROW_W'($urandom),
                      ATTR_W'($urandom));
        end
    endtask

    task automatic type_newlines(int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            send_item(OP_PUT_CHAR, NEWLINE_CODE, COL_W'($urandom), ROW_W'($urandom),
                      ATTR_W'($urandom));
        end
    endtask

    task automatic read_row_cells(logic [ROW_W-1:0] row, int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            send_item(OP_READ, CHAR_W'($urandom),
                      COL_W'($urandom_range(SCREEN_COLUMNS - 1)), row, ATTR_W'($urandom));
        end
    endtask

    // Writes one character at the cursor and reads the cell back.
    task automatic put_and_read(logic [CHAR_W-1:0] ch);
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        col = model_col[COL_W-1:0];
        row = model_row[ROW_W-1:0];
        send_item(OP_PUT_CHAR, ch, COL_W'($urandom), ROW_W'($urandom), ATTR_W'($urandom));
        send_item(OP_READ, CHAR_W'($urandom), col, row, ATTR_W'($urandom));
    endtask

    task automatic send_clear();
        send_item(OP_CLEAR, CHAR_W'($urandom), COL_W'($urandom), ROW_W'($urandom),
                  ATTR_W'($urandom));
    endtask

    task automatic send_random_item();
        op_t               cmd;
        logic [CHAR_W-1:0] ch;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        int unsigned       pick;
        pick = $urandom_range(99);
        ch   = CHAR_W'($urandom);
        col  = COL_W'(($urandom_range(99) < 85) ? $urandom_range(SCREEN_COLUMNS - 1)
                                                 : $urandom);
        row  = ROW_W'(($urandom_range(99) < 85) ? $urandom_range(SCREEN_ROWS - 1)
                                                 : $urandom);
        if (pick < 45)
        begin
            cmd = OP_PUT_CHAR;
            if ($urandom_range(99) < 8)
            begin
                ch = NEWLINE_CODE;
            end
        end
        else if (pick < 66)
        begin
            cmd = OP_PUT_AT;
        end
        else if (pick < 98)
        begin
            cmd = OP_READ;
        end
        else
        begin
            cmd = OP_CLEAR;
        end
        send_item(cmd, ch, col, row, ATTR_W'($urandom));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (console_outputs_due.size() != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    task automatic write_register(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ATTR_ADDR)
        begin
            model_attr = data[ATTR_W-1:0];
        end
        @(posedge clk);
    endtask

    task automatic check_attribute_register();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ATTR_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (prdata !== PDATA_W'(model_attr))
        begin
            note_error($sformatf("attribute register expected %h, got %h",
                                 PDATA_W'(model_attr), prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_state();
        check_attribute_register();
        // Only cell (0,0) is defined before the first clear, so only it is read.
        send_item(OP_PUT_CHAR, 8'h41, 7'h7F, 5'h1F, 8'hFF);
        send_item(OP_READ, 8'h00, 7'd0, 5'd0, 8'h00);
        send_item(OP_PUT_AT, 8'h55, COL_W'(SCREEN_COLUMNS), 5'd0, 8'h1E);
        send_item(OP_PUT_AT, 8'h55, 7'd0, ROW_W'(SCREEN_ROWS), 8'h1E);
        send_item(OP_PUT_AT, 8'hAA, 7'h7F, 5'h1F, 8'hE1);
        send_item(OP_READ, 8'h00, 7'h7F, 5'h1F, 8'hFF);
        send_item(OP_READ, 8'h00, COL_W'(SCREEN_COLUMNS), 5'd0, 8'h00);
        send_item(OP_CLEAR, 8'hFF, 7'h7F, 5'h1F, 8'hFF);
    endtask

    task automatic test_put_at_extremes();
        send_item(OP_PUT_AT, 8'h00, 7'd0, 5'd0, 8'h00);
        send_item(OP_PUT_AT, 8'hFF, COL_W'(SCREEN_COLUMNS - 1), ROW_W'(SCREEN_ROWS - 1),
                  8'hFF);
        send_item(OP_PUT_AT, NEWLINE_CODE, 7'd40, 5'd12, 8'h5A);
        send_item(OP_READ, 8'h00, 7'd0, 5'd0, 8'h00);
        send_item(OP_READ, 8'h00, COL_W'(SCREEN_COLUMNS - 1), ROW_W'(SCREEN_ROWS - 1),
                  8'h00);
        send_item(OP_READ, 8'h00, 7'd40, 5'd12, 8'h00);
        send_item(OP_READ, 8'h00, COL_W'(SCREEN_COLUMNS - 1), 5'd0, 8'h00);
        put_and_read(8'h00);
        put_and_read(8'hFF);
        type_newlines(1);
    endtask

    task automatic test_attribute_register();
        wait_idle();
        write_register(ATTR_ADDR, 32'h0000_0000);
        check_attribute_register();
        put_and_read(text_byte());
        wait_idle();
        write_register(ATTR_ADDR, 32'h0000_00FF);
        write_register(UNMAPPED_ADDR, 32'h0000_005A);
        check_attribute_register();
        put_and_read(text_byte());
        // A clear must leave the attribute register alone.
        send_clear();
        put_and_read(text_byte());
        wait_idle();
        write_register(ATTR_ADDR, $urandom);
        check_attribute_register();
    endtask

    task automatic test_line_wrap();
        send_clear();
        type_newlines(SCREEN_ROWS - 1);
        // Filling the last row wraps the cursor to the top without a scroll.
        type_chars(SCREEN_COLUMNS);
        read_row_cells(ROW_W'(SCREEN_ROWS - 1), 4);
        type_chars(SCREEN_COLUMNS + 5);
        read_row_cells(5'd0, 4);
        read_row_cells(5'd1, 2);
    endtask

    task automatic test_scroll();
        int n;
        send_clear();
        for (n = 0; n < 6; n++)
        begin
            send_item(OP_PUT_AT, CHAR_W'($urandom), COL_W'($urandom_range(SCREEN_COLUMNS - 1)),
                      (n < 3) ? 5'd1 : 5'(SCREEN_ROWS - 1), ATTR_W'($urandom));
        end
        type_newlines(SCREEN_ROWS - 1);
        type_chars(10);
        type_newlines(1);
        read_row_cells(5'd0, 4);
        read_row_cells(ROW_W'(SCREEN_ROWS - 2), 4);
        read_row_cells(ROW_W'(SCREEN_ROWS - 1), 3);
        type_chars(7);
        type_newlines(2);
        read_row_cells(ROW_W'(SCREEN_ROWS - 3), 3);
        read_row_cells(ROW_W'(SCREEN_ROWS - 1), 2);
    endtask

    task automatic test_backpressure();
        int n;
        // The receiver stalls for a long stretch while commands keep coming.
        steady          <= 1'b1;
        holds_requested <= holds_requested + 1;
        for (n = 0; n < 30; n++)
        begin
            send_random_item();
        end
        steady <= 1'b0;
    endtask

    task automatic test_random_traffic();
        int phase;
        int n;
        for (phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            case (phase)
                0: write_register(ATTR_ADDR, 32'h0000_0000);
                1: write_register(ATTR_ADDR, 32'hFFFF_FFFF);
                default: write_register(ATTR_ADDR, $urandom);
            endcase
            check_attribute_register();
            if (phase == 2)
            begin
                steady <= 1'b1;
            end
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 2 && n == 90)
                begin
                    steady <= 1'b0;
                end
                send_random_item();
            end
        end
    endtask

    task automatic check_result();
        console_output_t want;
        if (console_outputs_due.size() == 0)
        begin
            note_error($sformatf("unexpected result cell %h col %0d row %0d scroll %b",
                                 cell_value, cursor_column, cursor_row, did_scroll));
            return;
        end
        want = console_outputs_due.pop_front();
        if (cell_value !== want.cell_data || cursor_column !== want.column ||
            cursor_row !== want.row || did_scroll !== want.scrolled)
        begin
            note_error($sformatf(
                "expected cell %h col %0d row %0d scroll %b, got cell %h col %0d row %0d scroll %b",
                want.cell_data, want.column, want.row, want.scrolled,
                cell_value, cursor_column, cursor_row, did_scroll));
        end
    endtask

    // Result side: checks each transaction and drives out_ready.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            check_result();
        end
        if (holds_served != holds_requested)
        begin
            holds_served <= holds_requested;
            hold_left    <= HOLD_CYCLES;
            out_ready    <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_put_at_extremes();
        test_attribute_register();
        test_line_wrap();
        test_scroll();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && console_outputs_due.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: text_console_writer.f
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_datapath.sv
rtl/tcw_controller.sv
rtl/text_console_writer.sv
sim/tb_top.sv
